// ----- rtl/stepax_pkg.sv -----
// Shared types, register codes and reset values for the stepper axis pulse controller.
package stepax_pkg;

  localparam int unsigned IntervalWidth = 24;
  localparam int unsigned PulseWidthBits = 16;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned CfgIndexWidth = 3;

  localparam logic [IntervalWidth-1:0] StepIntervalReset = 24'd1000;
  localparam logic [PulseWidthBits-1:0] PulseWidthReset = 16'd5;
  localparam logic [CountWidth-1:0] RunToLimitReset = 32'hFFFF_FFFF;
  localparam logic [CountWidth-1:0] TicksMax = 32'hFFFF_FFFF;

  localparam logic DirForward = 1'b1;
  localparam logic DirBackward = 1'b0;

  localparam logic CmdTick = 1'b0;
  localparam logic CmdMove = 1'b1;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_STEP_INTERVAL = 3'd0,
    CFG_PULSE_WIDTH   = 3'd1,
    CFG_ROTARY_AXIS   = 3'd2,
    CFG_HAS_MIN_SW    = 3'd3,
    CFG_HAS_MAX_SW    = 3'd4,
    CFG_HOME_DIR      = 3'd5,
    CFG_END_DIR       = 3'd6,
    CFG_RUN_TO_LIMIT  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    AXIS_IDLE      = 3'd0,
    AXIS_TO_END    = 3'd1,
    AXIS_TO_HOME   = 3'd2,
    AXIS_AT_HOME   = 3'd3,
    AXIS_AT_END    = 3'd4
  } axis_state_t;

  // Limit switch that guards travel in the given direction.
  function automatic logic limit_in(input logic dir, input logic min_hit, input logic max_hit);
    limit_in = (dir == DirForward) ? max_hit : min_hit;
  endfunction

endpackage

// ----- rtl/stepper_axis_pulse_controller_core.sv -----
// Step/direction pulse generator for one axis: command decode, step timing and result register.
//
// One transaction on the command channel is either a one-microsecond tick or a move request,
// and each gives exactly one result transaction. The block takes one item per clock cycle:
// the step timing, limit checks and move acceptance are evaluated in a single pass between the
// axis state registers and the result register, so items flow back to back as long as the
// result side keeps up. A result is registered in the cycle after its item is accepted; while a result
// waits under a stall, the command side stalls in the same cycle. Configuration writes take
// effect on the next item and are meant to be made while the axis is idle.
module stepper_axis_pulse_controller_core
  import stepax_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // configuration write port
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  // command channel
  input  logic                     cmd_valid,
  output logic                     cmd_stall,
  input  logic                     command,
  input  logic                     direction,
  input  logic [CountWidth-1:0]    step_count,
  input  logic                     min_limit_hit,
  input  logic                     max_limit_hit,
  // result channel
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic                     step_level,
  output logic                     dir_level,
  output logic [2:0]               axis_state,
  output logic                     move_accepted,
  output logic                     pulse_done,
  output logic [CountWidth-1:0]    steps_taken
);

  // configuration registers
  logic [IntervalWidth-1:0]  step_interval;
  logic [PulseWidthBits-1:0] pulse_width;
  logic                      rotary_axis;
  logic                      has_min_switch;
  logic                      has_max_switch;
  logic                      home_direction;
  logic                      end_direction;
  logic [CountWidth-1:0]     run_to_limit_count;

  // axis state
  logic                  step_high, step_high_next;
  logic [CountWidth-1:0] ticks, ticks_next;
  logic                  cur_dir, cur_dir_next;
  logic [CountWidth-1:0] target_steps, target_steps_next;
  logic [CountWidth-1:0] step_counter, step_counter_next;
  logic                  moving, moving_next;

  logic                  accepted;
  logic                  done;
  logic                  move_ok;
  logic [CountWidth-1:0] ticks_inc;
  logic [CountWidth-1:0] counter_inc;
  axis_state_t           axis_code;
  logic                  cmd_accept;

  assign cmd_stall  = res_valid && res_stall;
  assign cmd_accept = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval      <= StepIntervalReset;
      pulse_width        <= PulseWidthReset;
      rotary_axis        <= 1'b0;
      has_min_switch     <= 1'b1;
      has_max_switch     <= 1'b1;
      home_direction     <= DirBackward;
      end_direction      <= DirForward;
      run_to_limit_count <= RunToLimitReset;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_STEP_INTERVAL: step_interval      <= cfg_data[IntervalWidth-1:0];
        CFG_PULSE_WIDTH:   pulse_width        <= cfg_data[PulseWidthBits-1:0];
        CFG_ROTARY_AXIS:   rotary_axis        <= cfg_data[0];
        CFG_HAS_MIN_SW:    has_min_switch     <= cfg_data[0];
        CFG_HAS_MAX_SW:    has_max_switch     <= cfg_data[0];
        CFG_HOME_DIR:      home_direction     <= cfg_data[0];
        CFG_END_DIR:       end_direction      <= cfg_data[0];
        CFG_RUN_TO_LIMIT:  run_to_limit_count <= cfg_data[CountWidth-1:0];
      endcase
    end
  end

  // move refused on zero count, active switch ahead, or run-to-limit on a non-rotary axis toward a missing switch
  always_comb begin
    move_ok = 1'b1;
    if (step_count == '0) begin
      move_ok = 1'b0;
    end else if (limit_in(direction, min_limit_hit, max_limit_hit)) begin
      move_ok = 1'b0;
    end else if (!rotary_axis && (step_count == run_to_limit_count)) begin
      if (!has_min_switch && (direction == home_direction)) begin
        move_ok = 1'b0;
      end else if (!has_max_switch && (direction == end_direction)) begin
        move_ok = 1'b0;
      end
    end
  end

  assign ticks_inc   = (ticks == TicksMax) ? ticks : ticks + 1'b1;
  assign counter_inc = step_counter + 1'b1;

  always_comb begin
    step_high_next    = step_high;
    ticks_next        = ticks;
    cur_dir_next      = cur_dir;
    target_steps_next = target_steps;
    step_counter_next = step_counter;
    moving_next       = moving;
    accepted          = 1'b0;
    done              = 1'b0;
    if (command == CmdMove) begin
      if (move_ok) begin
        cur_dir_next      = direction;
        target_steps_next = step_count;
        step_counter_next = '0;
        moving_next       = 1'b1;
        accepted          = 1'b1;
      end
    end else begin
      ticks_next = ticks_inc;
      priority if (!moving || limit_in(cur_dir, min_limit_hit, max_limit_hit)) begin
        moving_next = 1'b0;
      end else if (!step_high) begin
        if (ticks_inc >= {{(CountWidth-IntervalWidth){1'b0}}, step_interval}) begin
          step_high_next = 1'b1;
          ticks_next     = '0;
        end
      end else if (ticks_inc >= {{(CountWidth-PulseWidthBits){1'b0}}, pulse_width}) begin
        step_high_next    = 1'b0;
        done              = 1'b1;
        step_counter_next = counter_inc;
        if (counter_inc >= target_steps) begin
          moving_next = 1'b0;
        end
      end
    end
  end

  always_comb begin
    priority if (moving_next) begin
      axis_code = (cur_dir_next == DirForward) ? AXIS_TO_END : AXIS_TO_HOME;
    end else if (min_limit_hit) begin
      axis_code = AXIS_AT_HOME;
    end else if (max_limit_hit) begin
      axis_code = AXIS_AT_END;
    end else begin
      axis_code = AXIS_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_high    <= 1'b0;
      ticks        <= '0;
      cur_dir      <= DirForward;
      target_steps <= '0;
      step_counter <= '0;
      moving       <= 1'b0;
    end else if (cmd_accept) begin
      step_high    <= step_high_next;
      ticks        <= ticks_next;
      cur_dir      <= cur_dir_next;
      target_steps <= target_steps_next;
      step_counter <= step_counter_next;
      moving       <= moving_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // result payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      step_level    <= step_high_next;
      dir_level     <= cur_dir_next;
      axis_state    <= axis_code;
      move_accepted <= accepted;
      pulse_done    <= done;
      steps_taken   <= step_counter_next;
    end
  end

  a_state_holds_when_idle: assert property (@(posedge clk) disable iff (rst)
    !cmd_accept |=> $stable(step_high) && $stable(step_counter) && $stable(moving))
    else $error("axis state changed without an accepted transaction");

  a_moving_below_target: assert property (@(posedge clk) disable iff (rst)
    moving |-> step_counter < target_steps)
    else $error("axis still moving at or past its target");

  a_done_drops_step: assert property (@(posedge clk) disable iff (rst)
    res_valid && pulse_done |-> !step_level && !move_accepted)
    else $error("pulse_done without a falling step edge");

  a_accept_reports_motion: assert property (@(posedge clk) disable iff (rst)
    res_valid && move_accepted |->
      (axis_state == AXIS_TO_END) || (axis_state == AXIS_TO_HOME))
    else $error("accepted move not reported as moving");

endmodule
